// ----- rtl/core/prpt_pkg.sv -----
// Package for the physical range permission table.
// Holds the table geometry, command, status and owner codes and the entry layout.
// No dependencies.
`default_nettype none
package prpt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned PageW      = 64 - PageShift;
  localparam int unsigned TotW       = PageW + 1;
  localparam int unsigned GenW       = 32;
  localparam int unsigned EntryW     = PageW + TotW + 3 + GenW;

  localparam logic [2:0] CmdClear    = 3'd0;
  localparam logic [2:0] CmdRegister = 3'd1;
  localparam logic [2:0] CmdCheck    = 3'd2;
  localparam logic [2:0] CmdOwner    = 3'd3;
  localparam logic [2:0] CmdHostTest = 3'd4;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBad     = 3'd1;
  localparam logic [2:0] StBeyond  = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StOverlap = 3'd4;
  localparam logic [2:0] StOwner   = 3'd5;

  localparam logic [2:0] OwnUnknown  = 3'd0;
  localparam logic [2:0] OwnHostCode = 3'd1;
  localparam logic [2:0] OwnGuard    = 3'd4;
  localparam logic [2:0] OwnGuestRam = 3'd7;

  // access kinds that guest ram permits
  localparam logic [7:0] GuestRamAccess = 8'b1110_0111;

  typedef struct packed {
    logic [PageW-1:0] base;
    logic [TotW-1:0]  total;
    logic [2:0]       owner;
    logic [GenW-1:0]  gen;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/physical_range_permission_table_top.sv -----
// A beat is taken in idle and prepared; each entry is then read and evaluated, and the result is
// held until taken, after which the block returns to idle for the next beat. A register or host
// test sweeps the used entries until an overlap or hit; a check sweeps from the first entry
// once per covering range (up to entries^2 reads). Only one beat is in the block at a time.
// Reset: asynchronous, active low; clears the fill count, counters, limit and control.
// Depends on prpt_pkg and prpt_ram.
`default_nettype none
module physical_range_permission_table_top
  import prpt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [52:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [63:0] phys_address_i,
  input  wire logic [63:0] byte_length_i,
  input  wire logic [2:0]  owner_kind_i,
  input  wire logic [3:0]  access_kind_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  status_o,
  output      logic        verdict_o,
  output      logic [2:0]  found_owner_o,
  output      logic [31:0] entry_generation_o,
  output      logic [31:0] drops_seen_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPrep = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SEval = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [52:0]      limit_q;
  logic [CntW-1:0]  used_q, used_d;
  logic [GenW-1:0]  gen_q, gen_d;
  logic [31:0]      drop_q, drop_d;
  logic [2:0]       cmd_q;
  logic [63:0]      addr_q;
  logic [2:0]       own_q;
  logic [3:0]       acc_q;
  logic [PageW-1:0] base_q;
  logic [TotW-1:0]  end_q, cur_q, cur_d;
  logic             bad_q;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [2:0]       st_q, st_d, fo_q, fo_d;
  logic             vd_q, vd_d;
  logic             ram_we;
  entry_t           rd, wr;

  // address arithmetic of the incoming beat
  logic [63:0]      last_addr;
  logic [64:0]      sum_w;
  assign last_addr = phys_address_i + (byte_length_i - 64'd1);
  assign sum_w     = {1'b0, phys_address_i} + {1'b0, byte_length_i} - 65'd1;

  prpt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(used_q[IdxW-1:0]),
    .wdata_i(wr),
    .raddr_i(idx_q[IdxW-1:0]),
    .rdata_o(rd)
  );

  // entry geometry of the read word
  logic [TotW-1:0] e_base, e_end;
  logic            e_live, e_cover, e_ovl;
  assign e_base  = {1'b0, rd.base};
  assign e_end   = e_base + rd.total;
  assign e_live  = rd.total != '0;
  assign e_cover = e_live && (e_base <= cur_q) && (cur_q < e_end);
  assign e_ovl   = e_live && (e_base < end_q) && ({1'b0, base_q} < e_end);

  assign wr.base  = base_q;
  assign wr.total = end_q - {1'b0, base_q};
  assign wr.owner = own_q;
  assign wr.gen   = gen_q + 32'd1;

  // control sequencer
  always_comb begin
    state_d = state_q;
    used_d = used_q; gen_d = gen_q; drop_d = drop_q;
    cur_d = cur_q; idx_d = idx_q; st_d = st_q; vd_d = vd_q; fo_d = fo_q;
    ram_we = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) state_d = SPrep;
      end
      SPrep: begin
        st_d = StOk; vd_d = 1'b0; fo_d = OwnUnknown; idx_d = '0;
        cur_d = {1'b0, base_q};
        state_d = SRead;
        case (cmd_q)
          CmdClear: begin
            used_d = '0; gen_d = '0; drop_d = '0; state_d = SDone;
          end
          CmdRegister: begin
            if (own_q == OwnUnknown) begin
              st_d = StOwner; state_d = SDone;
            end else if (bad_q) begin
              st_d = StBad; state_d = SDone;
            end else if (limit_q != '0 && limit_q < end_q) begin
              st_d = StBeyond; state_d = SDone;
            end else if (used_q >= CntW'(TableDepth)) begin
              st_d = StFull; drop_d = drop_q + 32'd1; state_d = SDone;
            end else if (used_q == '0) begin
              ram_we = 1'b1; used_d = used_q + 1'b1; gen_d = gen_q + 32'd1;
              state_d = SDone;
            end
          end
          CmdCheck, CmdHostTest: begin
            if (bad_q) state_d = SDone;
            else if (used_q == '0) state_d = SDone;
          end
          CmdOwner: begin
            cur_d = {1'b0, addr_q[63:PageShift]};
            if (used_q == '0) state_d = SDone;
          end
          default: state_d = SDone;
        endcase
      end
      SRead: state_d = SEval;
      SEval: begin
        state_d = SRead;
        idx_d = idx_q + 1'b1;
        case (cmd_q)
          CmdRegister: begin
            if (e_ovl) begin
              st_d = StOverlap; state_d = SDone;
            end else if (idx_q + 1'b1 == used_q) begin
              ram_we = 1'b1; used_d = used_q + 1'b1; gen_d = gen_q + 32'd1;
              state_d = SDone;
            end
          end
          CmdHostTest: begin
            if (e_ovl && rd.owner >= OwnHostCode && rd.owner <= OwnGuard) begin
              vd_d = 1'b1; state_d = SDone;
            end else if (idx_q + 1'b1 == used_q) state_d = SDone;
          end
          CmdOwner: begin
            if (e_cover) begin
              fo_d = rd.owner; state_d = SDone;
            end else if (idx_q + 1'b1 == used_q) state_d = SDone;
          end
          default: begin
            // check: walk covering ranges until the end page
            if (e_cover) begin
              if (rd.owner != OwnGuestRam || acc_q[3] || !GuestRamAccess[acc_q[2:0]]) begin
                state_d = SDone;
              end else if (e_end >= end_q) begin
                vd_d = 1'b1; state_d = SDone;
              end else begin
                cur_d = e_end; idx_d = '0;
              end
            end else if (idx_q + 1'b1 == used_q) state_d = SDone;
          end
        endcase
      end
      SDone: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; gen_q <= '0; drop_q <= '0; limit_q <= '0;
    end else begin
      state_q <= state_d; used_q <= used_d; gen_q <= gen_d; drop_q <= drop_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // beat capture and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      cmd_q <= command_i; addr_q <= phys_address_i;
      own_q <= owner_kind_i; acc_q <= access_kind_i;
      bad_q  <= (byte_length_i == '0) || sum_w[64];
      base_q <= phys_address_i[63:PageShift];
      end_q  <= {1'b0, last_addr[63:PageShift]} + TotW'(1);
    end
    cur_q <= cur_d; idx_q <= idx_d; st_q <= st_d; vd_q <= vd_d; fo_q <= fo_d;
  end

  assign in_ready_o         = state_q == SIdle;
  assign out_valid_o        = state_q == SDone;
  assign status_o           = st_q;
  assign verdict_o          = vd_q;
  assign found_owner_o      = fo_q;
  assign entry_generation_o = gen_q;
  assign drops_seen_o       = drop_q;
endmodule
`default_nettype wire

// ----- rtl/core/prpt_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module prpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/prpt_checker.sv -----
// Port-level checker for the physical range permission table, bound to the top level.
// Depends on physical_range_permission_table_top ports only.
`default_nettype none
module prpt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic        verdict_o,
  input wire logic [2:0]  found_owner_o
);
  // no new beat while a result is pending
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready with result pending");
  // result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  // status code range
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'd5) else $error("bad status");
  // a found owner excludes a verdict and a nonzero status
  a_ex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_owner_o != 3'd0 |-> !verdict_o && status_o == 3'd0)
    else $error("fields mixed");
endmodule

bind physical_range_permission_table_top prpt_checker u_prpt_checker (.*);
`default_nettype wire

// ----- sim/tb_physical_range_permission_table_top.sv -----
// Self-checking bench for the physical range permission table top level.
// Drives command beats, predicts every result from its own table copy and checks them in order.
// Depends on prpt_pkg and the block's RTL.
`default_nettype none

// result fields of one beat
typedef struct packed {
  logic [2:0]  status;
  logic        verdict;
  logic [2:0]  found;
  logic [31:0] gen;
  logic [31:0] drops;
} prpt_result_t;

class range_table_scoreboard;
  logic [51:0]  base_pg [64];
  logic [52:0]  total_pg[64];
  logic [2:0]   owner   [64];
  int unsigned  used;
  logic [31:0]  gen_cnt;
  logic [31:0]  drop_cnt;
  logic [52:0]  page_limit;
  prpt_result_t pending[$];
  int unsigned  errors;

  function void clear_all();
    used = 0;
    gen_cnt = '0;
    drop_cnt = '0;
    page_limit = '0;
    pending.delete();
    errors = 0;
  endfunction

  // byte span to page span; 0 when empty or wrapping
  function bit span_pages(logic [63:0] addr, logic [63:0] len,
                          output logic [63:0] b, output logic [63:0] c);
    logic [64:0] last;
    b = '0;
    c = '0;
    last = {1'b0, addr} + {1'b0, len} - 65'd1;
    if (len == 0 || last[64]) return 0;
    b = addr >> prpt_pkg::PageShift;
    c = (last[63:0] >> prpt_pkg::PageShift) - b + 64'd1;
    return 1;
  endfunction

  function bit spans_touch(logic [63:0] b1, logic [63:0] c1, logic [63:0] b2, logic [63:0] c2);
    if (c1 == 0 || c2 == 0) return 0;
    return (b1 <= b2 + c2 - 1) && (b2 <= b1 + c1 - 1);
  endfunction

  function int find_page(logic [63:0] pg);
    for (int i = 0; i < used; i++) begin
      if (total_pg[i] == 0) continue;
      if (base_pg[i] <= pg && pg < 64'(base_pg[i]) + 64'(total_pg[i])) return i;
    end
    return -1;
  endfunction

  function logic [2:0] add_range(logic [63:0] addr, logic [63:0] len, logic [2:0] own);
    logic [63:0] b, c;
    if (own == prpt_pkg::OwnUnknown) return prpt_pkg::StOwner;
    if (!span_pages(addr, len, b, c)) return prpt_pkg::StBad;
    if (page_limit != 0 && 64'(page_limit) < b + c) return prpt_pkg::StBeyond;
    if (used >= prpt_pkg::TableDepth) begin
      drop_cnt++;
      return prpt_pkg::StFull;
    end
    for (int i = 0; i < used; i++)
      if (spans_touch(b, c, 64'(base_pg[i]), 64'(total_pg[i]))) return prpt_pkg::StOverlap;
    gen_cnt++;
    base_pg[used] = b[51:0];
    total_pg[used] = c[52:0];
    owner[used] = own;
    used++;
    return prpt_pkg::StOk;
  endfunction

  function bit access_ok(logic [63:0] addr, logic [63:0] len, logic [3:0] acc);
    logic [63:0] b, c, cur, stop, nxt;
    int idx;
    if (!span_pages(addr, len, b, c)) return 0;
    cur = b;
    stop = b + c;
    while (cur < stop) begin
      idx = find_page(cur);
      if (idx < 0 || owner[idx] != prpt_pkg::OwnGuestRam || acc > 7) return 0;
      if (!prpt_pkg::GuestRamAccess[acc[2:0]]) return 0;
      nxt = 64'(base_pg[idx]) + 64'(total_pg[idx]);
      if (nxt <= cur || nxt > stop) nxt = stop;
      cur = nxt;
    end
    return 1;
  endfunction

  function bit touches_host(logic [63:0] addr, logic [63:0] len);
    logic [63:0] b, c;
    if (!span_pages(addr, len, b, c)) return 0;
    for (int i = 0; i < used; i++)
      if (owner[i] >= prpt_pkg::OwnHostCode && owner[i] <= prpt_pkg::OwnGuard &&
          spans_touch(b, c, 64'(base_pg[i]), 64'(total_pg[i]))) return 1;
    return 0;
  endfunction

  // note an accepted command beat
  function void note_command(logic [2:0] cmd, logic [63:0] addr, logic [63:0] len,
                             logic [2:0] own, logic [3:0] acc);
    prpt_result_t r;
    int idx;
    r = '0;
    case (cmd)
      prpt_pkg::CmdClear: begin
        used = 0;
        gen_cnt = '0;
        drop_cnt = '0;
      end
      prpt_pkg::CmdRegister: r.status = add_range(addr, len, own);
      prpt_pkg::CmdCheck:    r.verdict = access_ok(addr, len, acc);
      prpt_pkg::CmdOwner: begin
        idx = find_page(addr >> prpt_pkg::PageShift);
        if (idx >= 0) r.found = owner[idx];
      end
      prpt_pkg::CmdHostTest: r.verdict = touches_host(addr, len);
      default: ;
    endcase
    r.gen = gen_cnt;
    r.drops = drop_cnt;
    pending.push_back(r);
  endfunction

  function void check_result(prpt_result_t got);
    prpt_result_t exp;
    if (pending.size() == 0) begin
      $display("%0t unexpected result beat %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status) begin
      $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
      errors++;
    end
    if (got.verdict !== exp.verdict) begin
      $display("%0t verdict exp %0d got %0d", $time, exp.verdict, got.verdict);
      errors++;
    end
    if (got.found !== exp.found) begin
      $display("%0t found_owner exp %0d got %0d", $time, exp.found, got.found);
      errors++;
    end
    if (got.gen !== exp.gen) begin
      $display("%0t generation exp %0d got %0d", $time, exp.gen, got.gen);
      errors++;
    end
    if (got.drops !== exp.drops) begin
      $display("%0t drops exp %0d got %0d", $time, exp.drops, got.drops);
      errors++;
    end
  endfunction
endclass

module tb_physical_range_permission_table_top;
  import prpt_pkg::*;

  localparam int unsigned CycleLimit = 60_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [52:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [63:0] phys_address_i = '0;
  logic [63:0] byte_length_i = '0;
  logic [2:0]  owner_kind_i = '0;
  logic [3:0]  access_kind_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        verdict_o;
  logic [2:0]  found_owner_o;
  logic [31:0] entry_generation_o;
  logic [31:0] drops_seen_o;

  range_table_scoreboard sb;
  bit          calm;          // no idling on either side
  longint unsigned cycles;
  logic [51:0] hint_pg;       // page near which random beats land

  physical_range_permission_table_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL physical_range_permission_table_top");
      $finish;
    end
  end

  // result side with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result({status_o, verdict_o, found_owner_o, entry_generation_o, drops_seen_o});
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic write_limit(logic [52:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.page_limit = v;
  endtask

  // valid stays high across back-to-back beats and drops only while idling
  task automatic send_beat(logic [2:0] cmd, logic [63:0] addr, logic [63:0] len,
                           logic [2:0] own, logic [3:0] acc);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    phys_address_i <= addr;
    byte_length_i <= len;
    owner_kind_i <= own;
    access_kind_i <= acc;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(cmd, addr, len, own, acc);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (64 * 64 * 2 + 20) @(posedge clk_i);
  endtask

  // random beat: mostly well-formed ranges near a moving page cursor
  task automatic random_beat();
    logic [2:0]  cmd;
    logic [63:0] addr, len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) cmd = CmdClear;
    else if (pick < 45) cmd = CmdRegister;
    else if (pick < 70) cmd = CmdCheck;
    else if (pick < 85) cmd = CmdOwner;
    else if (pick < 97) cmd = CmdHostTest;
    else cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(9) < 8) begin
      addr = {12'd0, hint_pg + 52'($urandom_range(40))} << PageShift;
      addr = addr + 64'($urandom_range(4095));
      len = 64'($urandom_range(1, 6 * 4096));
      if (cmd == CmdRegister) hint_pg = hint_pg + 52'($urandom_range(1, 8));
    end else begin
      addr = {$urandom, $urandom};
      len = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1 << 20));
    end
    send_beat(cmd, addr, len, ($urandom_range(4) == 0) ? OwnGuestRam : 3'($urandom),
              4'($urandom_range(8) + (($urandom_range(20) == 0) ? 7 : 0)));
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    cycles = 0;
    calm = 1'b0;
    hint_pg = 52'h100;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command, register errors, extremes
    send_beat(CmdRegister, 64'h1000, 64'h2000, OwnUnknown, 4'd0);
    send_beat(CmdRegister, 64'h1000, 64'd0, OwnGuestRam, 4'd0);
    send_beat(CmdRegister, '1, 64'd2, OwnGuestRam, 4'd0);
    send_beat(CmdRegister, 64'h1000, 64'h3000, OwnGuestRam, 4'd0);
    send_beat(CmdRegister, 64'h4000, 64'h1000, OwnHostCode, 4'd0);
    send_beat(CmdRegister, 64'h2fff, 64'h10, OwnGuard, 4'd0);
    send_beat(CmdRegister, 64'hffff_ffff_ffff_f000, 64'h1000, 3'd6, 4'd0);
    for (int a = 0; a < 9; a++) send_beat(CmdCheck, 64'h1800, 64'h2000, 3'd0, 4'(a));
    send_beat(CmdCheck, 64'h1000, 64'h4000, 3'd0, 4'd15);
    send_beat(CmdCheck, '1, '1, 3'd0, 4'd0);
    send_beat(CmdOwner, 64'h4abc, 64'd0, 3'd0, 4'd0);
    send_beat(CmdOwner, 64'h0, 64'd0, 3'd0, 4'd0);
    send_beat(CmdHostTest, 64'h3000, 64'h1001, 3'd0, 4'd0);
    send_beat(CmdHostTest, 64'h0, 64'h0, 3'd0, 4'd0);
    send_beat(3'd7, '1, '1, 3'd7, 4'hf);
    drain();
    write_limit(53'h20);
    send_beat(CmdRegister, 64'h1f000, 64'h1000, OwnGuestRam, 4'd0);
    send_beat(CmdRegister, 64'h20000, 64'h1000, OwnGuestRam, 4'd0);
    send_beat(CmdClear, '0, '0, 3'd0, 4'd0);
    drain();

    // fill the table then overflow it
    write_limit('1);
    for (int i = 0; i < 66; i++)
      send_beat(CmdRegister, 64'(i) << 13, 64'h1000, 3'($urandom_range(1, 7)), 4'd0);
    drain();

    // random phases over several limits
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(ph == 0 ? 53'd0 : ph == 4 ? 53'h10_0000_0000_0000 : 53'($urandom_range(300, 600)));
      calm = (ph == 2);
      send_beat(CmdClear, '0, '0, 3'd0, 4'd0);
      hint_pg = (ph == 0 || ph == 4) ? 52'($urandom) : 52'd0;
      for (int n = 0; n < 240; n++) random_beat();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS physical_range_permission_table_top");
    end else begin
      $display("FAIL physical_range_permission_table_top");
    end
    $finish;
  end
endmodule
